/* rtl/uart_echo_ring_buffers_defines.svh */
// ----------------------------------------------------------------------------
// uart_echo_ring_buffers_defines.svh
// Assertion macros for the UART echo ring buffers.
// ----------------------------------------------------------------------------
`ifndef UART_ECHO_RING_BUFFERS_DEFINES_SVH
`define UART_ECHO_RING_BUFFERS_DEFINES_SVH

`ifndef SYNTHESIS
`define UERB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uerb assertion failed");
`define UERB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uerb assertion failed");
`else
`define UERB_ASSERT_SAME(lbl, ante, cons)
`define UERB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/uerb_pkg.sv */
// ----------------------------------------------------------------------------
// uerb_pkg
// Shared types and constants of the UART echo ring buffers.
// ----------------------------------------------------------------------------
package uerb_pkg;

  localparam int RX_DEPTH = 16;
  localparam int TX_DEPTH = 16;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);

  typedef logic [RX_AW-1:0] rx_idx_t;
  typedef logic [TX_AW-1:0] tx_idx_t;

  typedef enum logic [1:0] {
    KIND_RX_BYTE  = 2'd0,
    KIND_HOST_PUT = 2'd1,
    KIND_HOST_GET = 2'd2,
    KIND_TX_EMPTY = 2'd3
  } kind_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic read;
  } dp_cmd_t;

endpackage

/* rtl/uerb_ctrl.sv */
// ----------------------------------------------------------------------------
// uerb_ctrl
// Sequencer: accept a word, update the queues, read the memories, present.
// ----------------------------------------------------------------------------
module uerb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output uerb_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q == S_EXEC) || (state_q == S_READ);
  assign accept = start_i && !busy_o;
  assign done_o = (state_q == S_OUT);

  assign cmd_o.latch = accept;
  assign cmd_o.exec  = (state_q == S_EXEC);
  assign cmd_o.read  = (state_q == S_READ);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_READ;
      S_READ: state_d = S_OUT;
      S_OUT: begin
        state_d = accept ? S_EXEC : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/uerb_dpath.sv */
// ----------------------------------------------------------------------------
// uerb_dpath
// Receive and transmit ring buffers with their indices and result registers.
// ----------------------------------------------------------------------------
module uerb_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uerb_pkg::dp_cmd_t cmd_i,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        data_i,
  output logic              tx_valid_o,
  output logic [7:0]        tx_byte_o,
  output logic              read_valid_o,
  output logic [7:0]        read_byte_o,
  output logic              rx_dropped_o,
  output logic              tx_dropped_o
);

  uerb_pkg::kind_e   kind_q;
  logic [7:0]        data_q;

  uerb_pkg::rx_idx_t rx_wr_q, rx_rd_q, rx_wr_next, rx_rd_next;
  uerb_pkg::tx_idx_t tx_wr_q, tx_rd_q, tx_wr_next, tx_rd_next;

  logic [7:0] rx_mem [uerb_pkg::RX_DEPTH];
  logic [7:0] tx_mem [uerb_pkg::TX_DEPTH];
  logic [7:0] rx_rdata_q, tx_rdata_q;

  logic tx_valid_q, read_valid_q, rx_drop_q, tx_drop_q;

  logic rx_room, tx_room, rx_push, tx_req, tx_push, tx_send, rx_pop;

  assign rx_wr_next = (rx_wr_q == uerb_pkg::rx_idx_t'(uerb_pkg::RX_DEPTH - 1)) ? '0
                    : rx_wr_q + uerb_pkg::rx_idx_t'(1);
  assign rx_rd_next = (rx_rd_q == uerb_pkg::rx_idx_t'(uerb_pkg::RX_DEPTH - 1)) ? '0
                    : rx_rd_q + uerb_pkg::rx_idx_t'(1);
  assign tx_wr_next = (tx_wr_q == uerb_pkg::tx_idx_t'(uerb_pkg::TX_DEPTH - 1)) ? '0
                    : tx_wr_q + uerb_pkg::tx_idx_t'(1);
  assign tx_rd_next = (tx_rd_q == uerb_pkg::tx_idx_t'(uerb_pkg::TX_DEPTH - 1)) ? '0
                    : tx_rd_q + uerb_pkg::tx_idx_t'(1);

  assign rx_room = (rx_wr_next != rx_rd_q);
  assign tx_room = (tx_wr_next != tx_rd_q);
  assign rx_push = (kind_q == uerb_pkg::KIND_RX_BYTE) && rx_room;
  assign tx_req  = (kind_q == uerb_pkg::KIND_HOST_PUT) || rx_push;
  assign tx_push = tx_req && tx_room;
  // a successful enqueue leaves the queue non-empty, so it always sends
  assign tx_send = tx_push
                || ((kind_q == uerb_pkg::KIND_TX_EMPTY) && (tx_wr_q != tx_rd_q));
  assign rx_pop  = (kind_q == uerb_pkg::KIND_HOST_GET) && (rx_wr_q != rx_rd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= uerb_pkg::kind_e'(kind_i);
      data_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wr_q      <= '0;
      rx_rd_q      <= '0;
      tx_wr_q      <= '0;
      tx_rd_q      <= '0;
      tx_valid_q   <= 1'b0;
      read_valid_q <= 1'b0;
      rx_drop_q    <= 1'b0;
      tx_drop_q    <= 1'b0;
    end else if (cmd_i.exec) begin
      if (rx_push) rx_wr_q <= rx_wr_next;
      if (rx_pop)  rx_rd_q <= rx_rd_next;
      if (tx_push) tx_wr_q <= tx_wr_next;
      if (tx_send) tx_rd_q <= tx_rd_next;
      tx_valid_q   <= tx_send;
      read_valid_q <= rx_pop;
      rx_drop_q    <= (kind_q == uerb_pkg::KIND_RX_BYTE) && !rx_room;
      tx_drop_q    <= tx_req && !tx_room;
    end
  end

  // write in the update cycle, read the advanced slot in the following cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && rx_push) rx_mem[rx_wr_next] <= data_q;
    if (cmd_i.exec && tx_push) tx_mem[tx_wr_next] <= data_q;
    if (cmd_i.read) begin
      rx_rdata_q <= rx_mem[rx_rd_q];
      tx_rdata_q <= tx_mem[tx_rd_q];
    end
  end

  assign tx_valid_o   = tx_valid_q;
  assign tx_byte_o    = tx_valid_q ? tx_rdata_q : 8'h00;
  assign read_valid_o = read_valid_q;
  assign read_byte_o  = read_valid_q ? rx_rdata_q : 8'h00;
  assign rx_dropped_o = rx_drop_q;
  assign tx_dropped_o = tx_drop_q;

endmodule

/* rtl/uart_echo_ring_buffers.sv */
// ----------------------------------------------------------------------------
// uart_echo_ring_buffers
// Receive and transmit byte queues between a UART and a host, with echo.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive kind_i and data_i and raise start_i; the word is
//   taken at a rising edge where start_i is high and busy_o is low.
//   kind_i: line byte received, host put, host get, transmitter empty.
//   Result channel: done_o is high for exactly one cycle and qualifies
//   tx_valid_o/tx_byte_o, read_valid_o/read_byte_o, rx_dropped_o and
//   tx_dropped_o. The receiver cannot stall; it must take the word then.
//   Sequence: after the accepting edge the controller passes through S_EXEC
//   (index update) and S_READ (registered read port of each queue memory),
//   then raises done_o in S_OUT. A new word is not accepted while busy_o is
//   high, but may be accepted in the done_o cycle.
//   Each queue holds at most depth-1 bytes.
//   Reset: all indices cleared, both queues empty, no result pending; the
//   queue memories are not cleared.
// ----------------------------------------------------------------------------
`include "uart_echo_ring_buffers_defines.svh"

module uart_echo_ring_buffers (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] data_i,
  output logic       done_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o,
  output logic       rx_dropped_o,
  output logic       tx_dropped_o
);

  uerb_pkg::dp_cmd_t dp_cmd;

  uerb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (dp_cmd)
  );

  uerb_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .kind_i       (kind_i),
    .data_i       (data_i),
    .tx_valid_o   (tx_valid_o),
    .tx_byte_o    (tx_byte_o),
    .read_valid_o (read_valid_o),
    .read_byte_o  (read_byte_o),
    .rx_dropped_o (rx_dropped_o),
    .tx_dropped_o (tx_dropped_o)
  );

  `UERB_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o && dp_cmd.exec)
  `UERB_ASSERT_NEXT(a_exec_read, dp_cmd.exec, dp_cmd.read && !done_o)
  `UERB_ASSERT_SAME(a_done_after_read, done_o, $past(dp_cmd.read))
  `UERB_ASSERT_SAME(a_one_action, done_o, !(tx_valid_o && (read_valid_o || tx_dropped_o)))

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the UART echo ring buffers word by word against a local model of
// both byte queues: empty and full queues, echo, host put and get, and long
// random event streams under varied command gaps.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit = 100_000;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       rx_dropped;
    logic       tx_dropped;
  } outcome_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic [1:0] kind_i = uerb_pkg::KIND_RX_BYTE;
  logic [7:0] data_i = 8'h00;
  logic       busy_o;
  logic       done_o;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic       read_valid_o;
  logic [7:0] read_byte_o;
  logic       rx_dropped_o;
  logic       tx_dropped_o;

  logic [7:0]        rx_mem [uerb_pkg::RX_DEPTH];
  logic [7:0]        tx_mem [uerb_pkg::TX_DEPTH];
  uerb_pkg::rx_idx_t rx_wr = '0;
  uerb_pkg::rx_idx_t rx_rd = '0;
  uerb_pkg::tx_idx_t tx_wr = '0;
  uerb_pkg::tx_idx_t tx_rd = '0;

  outcome_t    outcome_q [$];
  int          errors = 0;
  int unsigned cycle_count = 0;

  uart_echo_ring_buffers i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .data_i       (data_i),
    .done_o       (done_o),
    .tx_valid_o   (tx_valid_o),
    .tx_byte_o    (tx_byte_o),
    .read_valid_o (read_valid_o),
    .read_byte_o  (read_byte_o),
    .rx_dropped_o (rx_dropped_o),
    .tx_dropped_o (tx_dropped_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic uerb_pkg::rx_idx_t rx_advance(uerb_pkg::rx_idx_t i);
    return (i == uerb_pkg::rx_idx_t'(uerb_pkg::RX_DEPTH - 1)) ? '0
         : uerb_pkg::rx_idx_t'(i + 1'b1);
  endfunction

  function automatic uerb_pkg::tx_idx_t tx_advance(uerb_pkg::tx_idx_t i);
    return (i == uerb_pkg::tx_idx_t'(uerb_pkg::TX_DEPTH - 1)) ? '0
         : uerb_pkg::tx_idx_t'(i + 1'b1);
  endfunction

  function automatic void tx_send(inout outcome_t o);
    if (tx_wr != tx_rd) begin
      tx_rd      = tx_advance(tx_rd);
      o.tx_valid = 1'b1;
      o.tx_byte  = tx_mem[tx_rd];
    end
  endfunction

  function automatic void tx_enqueue(logic [7:0] d, inout outcome_t o);
    uerb_pkg::tx_idx_t n;
    n = tx_advance(tx_wr);
    if (n != tx_rd) begin
      tx_wr     = n;
      tx_mem[n] = d;
      tx_send(o);
    end else begin
      o.tx_dropped = 1'b1;
    end
  endfunction

  function automatic outcome_t queue_event_outcome(uerb_pkg::kind_e k, logic [7:0] d);
    outcome_t          o;
    uerb_pkg::rx_idx_t n;
    o = '0;
    case (k)
      uerb_pkg::KIND_RX_BYTE: begin
        n = rx_advance(rx_wr);
        if (n != rx_rd) begin
          rx_wr     = n;
          rx_mem[n] = d;
          tx_enqueue(d, o);
        end else begin
          o.rx_dropped = 1'b1;
        end
      end
      uerb_pkg::KIND_HOST_PUT: tx_enqueue(d, o);
      uerb_pkg::KIND_HOST_GET: begin
        if (rx_wr != rx_rd) begin
          rx_rd        = rx_advance(rx_rd);
          o.read_valid = 1'b1;
          o.read_byte  = rx_mem[rx_rd];
        end
      end
      default: tx_send(o);
    endcase
    return o;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (outcome_q.size() == 0) begin
        $error("result word with none outstanding");
        errors++;
      end else begin
        want = outcome_q.pop_front();
        check_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid_o));
        check_field("tx_byte", want.tx_byte, tx_byte_o);
        check_field("read_valid", 8'(want.read_valid), 8'(read_valid_o));
        check_field("read_byte", want.read_byte, read_byte_o);
        check_field("rx_dropped", 8'(want.rx_dropped), 8'(rx_dropped_o));
        check_field("tx_dropped", 8'(want.tx_dropped), 8'(tx_dropped_o));
      end
    end
  end

  task automatic send_word(uerb_pkg::kind_e k, logic [7:0] d);
    @(negedge clk_i);
    start_i <= 1'b1;
    kind_i  <= k;
    data_i  <= d;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    outcome_q.push_back(queue_event_outcome(k, d));
  endtask

  task automatic idle_gap(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_queues();
    send_word(uerb_pkg::KIND_HOST_GET, 8'hFF);
    send_word(uerb_pkg::KIND_TX_EMPTY, 8'h00);
    drain_results();
  endtask

  task automatic test_put_extremes();
    send_word(uerb_pkg::KIND_HOST_PUT, 8'h00);
    send_word(uerb_pkg::KIND_HOST_PUT, 8'hFF);
    send_word(uerb_pkg::KIND_TX_EMPTY, 8'hFF);
    drain_results();
  endtask

  task automatic test_receive_full();
    for (int i = 0; i < uerb_pkg::RX_DEPTH - 1; i++) begin
      send_word(uerb_pkg::KIND_RX_BYTE,
                (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(255)));
    end
    send_word(uerb_pkg::KIND_RX_BYTE, 8'hFF);
    send_word(uerb_pkg::KIND_HOST_GET, 8'h00);
    send_word(uerb_pkg::KIND_HOST_GET, 8'hFF);
    send_word(uerb_pkg::KIND_RX_BYTE, 8'hA5);
    send_word(uerb_pkg::KIND_HOST_GET, 8'h5A);
    drain_results();
  endtask

  task automatic test_random_traffic(int unsigned pct, int unsigned count);
    int unsigned     sent;
    int unsigned     mode;
    int unsigned     burst;
    int unsigned     r;
    uerb_pkg::kind_e k;
    sent = 0;
    while (sent < count) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(10, 40);
      for (int unsigned b = 0; b < burst && sent < count; b++) begin
        r = $urandom_range(99);
        case (mode)
          0: k = (r < 70) ? uerb_pkg::KIND_RX_BYTE : (r < 80) ? uerb_pkg::KIND_HOST_PUT :
                 (r < 92) ? uerb_pkg::KIND_HOST_GET : uerb_pkg::KIND_TX_EMPTY;
          1: k = (r < 15) ? uerb_pkg::KIND_RX_BYTE : (r < 25) ? uerb_pkg::KIND_HOST_PUT :
                 (r < 85) ? uerb_pkg::KIND_HOST_GET : uerb_pkg::KIND_TX_EMPTY;
          default: k = uerb_pkg::kind_e'($urandom_range(3));
        endcase
        idle_gap(pct);
        send_word(k, 8'($urandom_range(255)));
        sent++;
      end
      if ($urandom_range(9) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_queues();
    test_put_extremes();
    test_receive_full();
    test_random_traffic(0, 190);
    test_random_traffic(51, 190);
    test_random_traffic(0, 180);
    test_random_traffic(28, 190);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
